// ----- rtl/core/ctc_pkg.sv -----
package ctc_pkg;

   // Field widths of the token channel
   localparam int KIND_W   = 3;
   localparam int OFFSET_W = 16;
   localparam int TLEN_W   = 8;
   localparam int CHAR_W   = 8;
   localparam int KWIDX_W  = 5;

   // Token kinds
   localparam logic [KIND_W-1:0] KIND_KEYWORD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CONSTANT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_IDENT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OPERATOR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DELIM     = 3'd5;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LESS   = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GREATER = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

   // Keyword table; text is right-justified, first character highest
   localparam int KW_COUNT = 23;
   localparam int KW_LEN_W = 4;

   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "if", "else", "while", "do", "break", "continue", "int", "double",
      "float", "return", "char", "case", "sizeof", "long", "short", "typedef",
      "switch", "unsigned", "void", "static", "struct", "goto", "#include"
   };

   localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4, 4'd4,
      4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4, 4'd8
   };

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              end_of_line;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   token_kind;
      logic [OFFSET_W-1:0] start_offset;
      logic [TLEN_W-1:0]   token_length;
      logic [CHAR_W-1:0]   symbol;
      logic [KWIDX_W-1:0]  keyword_index;
      logic                run_last;
   } rsp_type;

endpackage

// ----- rtl/core/c_token_classifier_core.sv -----
// Channel  Direction  Payload               Handshake
// req      in         ctc_pkg::req_type     req_valid / req_ready
// rsp      out        ctc_pkg::rsp_type     rsp_valid / rsp_ready
//
// A character is taken into an input register, classified in the next cycle
// against the word state and written as one entry (one or two tokens) into a
// four-entry token queue. Sustained rate is one character per cycle while
// each character gives at most one token and rsp is not stalled; a character
// that gives two tokens is limited by the single token read port of the queue.
// A token is offered once its entry has been written into the queue register.
// Synchronous reset clears the pipeline, the queue and the line/word state.
// req_ready depends only on registered occupancy; a stalled rsp fills the queue.
module c_token_classifier_core #(
   parameter int LINE_BYTES   = 65536,
   parameter int WORD_LEN_MAX = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctc_pkg::rsp_type rsp_data
);

   localparam int OFS_W   = $clog2(LINE_BYTES);
   localparam int WL_W    = $clog2(WORD_LEN_MAX + 1);
   localparam int DEPTH   = 4;
   localparam int PTR_W   = 2;
   localparam int CNT_W   = 3;

   typedef struct packed {
      ctc_pkg::rsp_type tok0;
      ctc_pkg::rsp_type tok1;
      logic             two;
   } entry_type;

   // Input register
   logic             stg_valid_ff, stg_valid_in;
   ctc_pkg::req_type stg_data_ff;

   // Line and word state
   logic [OFS_W-1:0]             line_ofs_ff, line_ofs_in;
   logic [OFS_W-1:0]             word_start_ff, word_start_in;
   logic [WL_W-1:0]              word_len_ff, word_len_in;
   logic                         first_dig_ff, first_dig_in;
   logic                         all_dig_ff, all_dig_in;
   logic [ctc_pkg::KW_COUNT-1:0] kw_mask_ff, kw_mask_in;

   // Token queue
   entry_type        queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sel_ff, sel_in;

   logic      push, pop, rsp_fire;
   entry_type push_entry;
   entry_type head;

   // Accept while queue plus staged character leave room for one more entry
   assign req_ready    = ({1'b0, count_ff} + {{CNT_W{1'b0}}, stg_valid_ff})
                         < (CNT_W + 1)'(DEPTH);
   assign stg_valid_in = req_valid && req_ready;

   // Classification of the staged character
   always_comb begin
      logic [7:0]                   c;
      logic                         eol, is_dig, is_delim, is_op, is_paren;
      logic [WL_W-1:0]              add_len;
      logic [OFS_W-1:0]             add_start;
      logic                         add_first, add_all;
      logic [ctc_pkg::KW_COUNT-1:0] add_mask, kw_hit;
      logic [WL_W-1:0]              f_len;
      logic [OFS_W-1:0]             f_start;
      logic                         f_first, f_all;
      logic [ctc_pkg::KW_COUNT-1:0] f_mask;
      logic [2:0]                   sh;
      logic [7:0]                   kw_ch;
      logic                         word_emit, sym_emit, found;
      logic [ctc_pkg::KWIDX_W-1:0]  kw_idx;
      logic [WL_W+7:0]              len_ext;
      logic [OFS_W+15:0]            ofs_ext, wst_ext;
      ctc_pkg::rsp_type             wtok, stok;

      c        = stg_data_ff.char_code;
      eol      = stg_data_ff.end_of_line;
      is_dig   = (c >= ctc_pkg::CH_ZERO) && (c <= ctc_pkg::CH_NINE);
      is_op    = c inside {ctc_pkg::CH_PLUS, ctc_pkg::CH_MINUS, ctc_pkg::CH_STAR,
                           ctc_pkg::CH_SLASH, ctc_pkg::CH_GREATER, ctc_pkg::CH_LESS,
                           ctc_pkg::CH_EQUAL};
      is_paren = c inside {ctc_pkg::CH_LPAREN, ctc_pkg::CH_RPAREN,
                           ctc_pkg::CH_LBRACE, ctc_pkg::CH_RBRACE};
      is_delim = is_op || is_paren ||
                 (c inside {ctc_pkg::CH_SPACE, ctc_pkg::CH_COMMA, ctc_pkg::CH_SEMI,
                            ctc_pkg::CH_LBRACK, ctc_pkg::CH_RBRACK});

      // Word state after extending with this character
      add_mask = (word_len_ff == '0) ? '1 : kw_mask_ff;
      for (int i = 0; i < ctc_pkg::KW_COUNT; i++) begin
         sh    = 3'(ctc_pkg::KW_LEN[i] - 4'd1 - {1'b0, word_len_ff[2:0]});
         kw_ch = ctc_pkg::KW_TEXT[i][{sh, 3'b000} +: 8];
         if ((word_len_ff >= WL_W'(ctc_pkg::KW_LEN[i])) || (kw_ch != c)) begin
            add_mask[i] = 1'b0;
         end
      end
      if (word_len_ff == '0) begin
         add_start = line_ofs_ff;
         add_first = is_dig;
         add_all   = is_dig;
      end else begin
         add_start = word_start_ff;
         add_first = first_dig_ff;
         add_all   = all_dig_ff && is_dig;
      end
      add_len = (word_len_ff == WL_W'(WORD_LEN_MAX)) ? word_len_ff : word_len_ff + 1'b1;

      // Word to finish: the pending one at a delimiter, the extended one at end of line
      if (is_delim) begin
         f_len = word_len_ff; f_start = word_start_ff; f_first = first_dig_ff;
         f_all = all_dig_ff;  f_mask  = kw_mask_ff;
      end else begin
         f_len = add_len; f_start = add_start; f_first = add_first;
         f_all = add_all; f_mask  = add_mask;
      end
      word_emit = (is_delim || eol) && (f_len != '0);
      sym_emit  = is_op || is_paren;

      // First keyword whose length matches and is still a candidate
      for (int i = 0; i < ctc_pkg::KW_COUNT; i++) begin
         kw_hit[i] = f_mask[i] && (f_len == WL_W'(ctc_pkg::KW_LEN[i]));
      end
      found  = 1'b0;
      kw_idx = '0;
      for (int i = ctc_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (kw_hit[i]) begin
            found  = 1'b1;
            kw_idx = ctc_pkg::KWIDX_W'(i);
         end
      end

      len_ext = {8'd0, f_len};
      ofs_ext = {16'd0, line_ofs_ff};
      wst_ext = {16'd0, f_start};

      wtok.start_offset  = wst_ext[15:0];
      wtok.token_length  = (len_ext > (WL_W + 8)'(255)) ? 8'hFF : len_ext[7:0];
      wtok.symbol        = '0;
      wtok.keyword_index = found ? kw_idx : '0;
      wtok.run_last      = !sym_emit;
      if (found)           wtok.token_kind = ctc_pkg::KIND_KEYWORD;
      else if (f_all)      wtok.token_kind = ctc_pkg::KIND_CONSTANT;
      else if (f_first)    wtok.token_kind = ctc_pkg::KIND_NOT_IDENT;
      else                 wtok.token_kind = ctc_pkg::KIND_IDENT;

      stok.token_kind    = is_op ? ctc_pkg::KIND_OPERATOR : ctc_pkg::KIND_DELIM;
      stok.start_offset  = ofs_ext[15:0];
      stok.token_length  = 8'd1;
      stok.symbol        = c;
      stok.keyword_index = '0;
      stok.run_last      = 1'b1;

      push            = stg_valid_ff && (word_emit || sym_emit);
      push_entry.two  = word_emit && sym_emit;
      push_entry.tok0 = word_emit ? wtok : stok;
      push_entry.tok1 = stok;

      // Next line and word state
      line_ofs_in   = line_ofs_ff;
      word_start_in = word_start_ff;
      word_len_in   = word_len_ff;
      first_dig_in  = first_dig_ff;
      all_dig_in    = all_dig_ff;
      kw_mask_in    = kw_mask_ff;
      if (stg_valid_ff) begin
         if (eol) begin
            line_ofs_in   = '0;
            word_start_in = '0;
         end else begin
            line_ofs_in = (line_ofs_ff == OFS_W'(LINE_BYTES - 1)) ? '0 : line_ofs_ff + 1'b1;
         end
         if (eol || is_delim) begin
            word_len_in  = '0;
            first_dig_in = 1'b0;
            all_dig_in   = 1'b1;
            kw_mask_in   = '1;
         end else begin
            word_start_in = add_start;
            word_len_in   = add_len;
            first_dig_in  = add_first;
            all_dig_in    = add_all;
            kw_mask_in    = add_mask;
         end
      end
   end

   // Token queue output side
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = sel_ff ? head.tok1 : head.tok0;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign pop       = rsp_fire && (sel_ff || !head.two);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(CNT_W-1){1'b0}}, push} - {{(CNT_W-1){1'b0}}, pop};
      sel_in    = sel_ff;
      if (rsp_fire) begin
         sel_in = !pop;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         line_ofs_ff   <= '0;
         word_start_ff <= '0;
         word_len_ff   <= '0;
         first_dig_ff  <= 1'b0;
         all_dig_ff    <= 1'b1;
         kw_mask_ff    <= '1;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         sel_ff        <= 1'b0;
      end else begin
         stg_valid_ff  <= stg_valid_in;
         line_ofs_ff   <= line_ofs_in;
         word_start_ff <= word_start_in;
         word_len_ff   <= word_len_in;
         first_dig_ff  <= first_dig_in;
         all_dig_ff    <= all_dig_in;
         kw_mask_ff    <= kw_mask_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         sel_ff        <= sel_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (stg_valid_in) begin
         stg_data_ff <= req_data;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("token queue occupancy out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH) || pop))
      else $error("token queue written while full");

   a_second_only_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && sel_ff) |-> (head.two && rsp_data.run_last))
      else $error("second token offered from a single-token entry");

   a_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !sel_ff && head.two) |-> !rsp_data.run_last)
      else $error("first of two tokens marked last");

   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.token_length != '0))
      else $error("token with zero length");

endmodule
